### src/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");

`endif

### src/sha_pkg.sv
// sha-256 package: command codes, constants, round helpers, fsm state type
// no dependencies
package sha_pkg;

    localparam int QueueDepth = 4;
    localparam int BufDepth   = 64;

    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } state_t;

    localparam logic [255:0] InitH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            unique case (t)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### src/sha_ram.sv
// generic single-port ram with registered read
// no dependencies
module sha_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### src/sha_front.sv
// front end: accepts command/byte items and queues them for the core
// depends on sha_pkg
module sha_front #(
    parameter int Depth = sha_pkg::QueueDepth
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  sha_pkg::item_t in_item,
    input  logic           take,
    output logic           avail,
    output sha_pkg::item_t out_item
);
    import sha_pkg::*;

    localparam int Aw = $clog2(Depth);

    item_t            q_reg [Depth];
    logic [Aw-1:0]    wr_reg, rd_reg;
    logic [Aw:0]      cnt_reg;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == (Aw+1)'(Depth));
    assign avail    = (cnt_reg != '0);
    assign out_item = q_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = take && avail;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
        end
    end
endmodule

### src/sha_core.sv
// back end: block buffer, message schedule, round loop, padding, digest output
// depends on sha_pkg and sha_ram
module sha_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           avail,
    input  sha_pkg::item_t item,
    output logic           take,
    output logic           empty,
    input  logic           pop,
    output logic [31:0]    digest_word,
    output logic [2:0]     word_index,
    output logic           last_word
);
    import sha_pkg::*;

    state_t          state_reg, state_next;
    logic [5:0]      fill_reg, fill_next;
    logic [63:0]     len_reg, len_next;
    logic [255:0]    h_reg, h_next;
    logic [255:0]    v_reg, v_next;
    logic [511:0]    w_reg, w_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic [63:0]     total_reg, total_next;
    logic            fin_reg, fin_next;
    logic            pad2_reg, pad2_next;
    logic            ovalid_reg, ovalid_next;
    logic [2:0]      oidx_reg, oidx_next;

    logic            ram_we;
    logic [5:0]      ram_addr;
    logic [7:0]      ram_wdata, ram_rdata;

    sha_ram #(.Width(8), .Depth(BufDepth)) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // round datapath
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wt, wnew, w1, w14;
    assign {a, b, c, d, e, f, g, h} = v_reg;
    assign wt  = w_reg[511:480];
    assign w1  = w_reg[479:448];
    assign w14 = w_reg[63:32];
    assign wnew = (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10)) + w_reg[223:192]
                + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + wt;
    assign t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
              + round_k(cnt_reg[5:0]) + wt;
    assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

    logic [255:0] h_sum;
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_sum[i*32 +: 32] = h_reg[i*32 +: 32] + v_reg[i*32 +: 32];
        end
    end

    assign empty       = !ovalid_reg;
    assign digest_word = h_reg[255 - 32*oidx_reg -: 32];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            h_reg      <= InitH;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            pad2_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            oidx_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            h_reg      <= h_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            pad2_reg   <= pad2_next;
            ovalid_reg <= ovalid_next;
            oidx_reg   <= oidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        w_reg     <= w_next;
        total_reg <= total_next;
    end

    // padding byte for a buffer position during finish
    function automatic logic [7:0] pad_byte(input logic [5:0] p, input logic [5:0] pos,
                                            input logic second, input logic [63:0] tot);
        logic [7:0] r;
        begin
            if (p >= 6'd56 && !second && pos < 6'd56)
            begin
                r = tot[63 - 8*(p - 6'd56) -: 8];
            end
            else if (p >= 6'd56 && second)
            begin
                r = tot[63 - 8*(p - 6'd56) -: 8];
            end
            else if (!second && p == pos)
            begin
                r = PadByte;
            end
            else
            begin
                r = 8'h00;
            end
            return r;
        end
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        h_next      = h_reg;
        v_next      = v_reg;
        w_next      = w_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        fin_next    = fin_reg;
        pad2_next   = pad2_reg;
        ovalid_next = ovalid_reg;
        oidx_next   = oidx_reg;
        take        = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = cnt_reg[5:0];
        ram_wdata   = 8'h00;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (avail)
                begin
                    take = 1'b1;
                    if (item.cmd == CMD_ABSORB)
                    begin
                        ram_we    = 1'b1;
                        ram_addr  = fill_reg;
                        ram_wdata = item.data_byte;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            fin_next   = 1'b0;
                            cnt_next   = '0;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        total_next = len_reg + {55'd0, fill_reg, 3'd0};
                        fin_next   = 1'b1;
                        pad2_next  = 1'b0;
                        cnt_next   = {1'b0, fill_reg};
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // write 0x80, zeros and (if room) the length up to the block end
                ram_we    = 1'b1;
                ram_addr  = cnt_reg[5:0];
                ram_wdata = pad_byte(cnt_reg[5:0], fill_reg, 1'b0, total_reg);
                if (cnt_reg[5:0] == 6'd63)
                begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_LEN:
            begin
                // second padding block: zeros then the length
                ram_we    = 1'b1;
                ram_addr  = cnt_reg[5:0];
                ram_wdata = pad_byte(cnt_reg[5:0], fill_reg, 1'b1, total_reg);
                if (cnt_reg[5:0] == 6'd63)
                begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_LOAD:
            begin
                // registered read data follows its address in the next cycle; shift it into the schedule
                ram_addr = cnt_reg[5:0];
                if (cnt_reg != 7'd0)
                begin
                    w_next = {w_reg[503:0], ram_rdata};
                end
                if (cnt_reg == 7'd64)
                begin
                    cnt_next   = '0;
                    v_next     = h_reg;
                    state_next = ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ROUND:
            begin
                v_next   = {t1 + t2, a, b, c, d + t1, e, f, g};
                w_next   = {w_reg[479:0], wnew};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                h_next = h_sum;
                if (!fin_reg)
                begin
                    len_next   = len_reg + 64'd512;
                    state_next = ST_IDLE;
                end
                else if (fill_reg >= 6'd56 && !pad2_reg)
                begin
                    pad2_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_LEN;
                end
                else
                begin
                    ovalid_next = 1'b1;
                    oidx_next   = '0;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (pop)
                begin
                    if (oidx_reg == 3'd7)
                    begin
                        ovalid_next = 1'b0;
                        oidx_next   = '0;
                        h_next      = InitH;
                        len_next    = '0;
                        fill_next   = '0;
                        fin_next    = 1'b0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

### src/sha256_byte_stream_hasher.sv
// sha-256 over a byte stream: absorb one byte a cycle while idle and the queue holds data;
// per block: 64 buffer reads into the schedule, then 64 rounds, one round a cycle, then the add
// finish: pad sweep from the pending fill position to the block end, one compression, 8 words
// with 56 or more bytes pending a length sweep and a second compression follow
// the 4-entry input queue lets bytes arrive while a block compresses
// reset (rst_n low, async): hash returns to initial values, length and fill cleared
module sha256_byte_stream_hasher #(
    parameter int QueueDepth = sha_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha_pkg::*;
    `include "assert_macros.svh"

    item_t in_item, q_item;
    logic  avail, take;

    assign in_item.cmd       = cmd;
    assign in_item.data_byte = data_byte;

    sha_front #(.Depth(QueueDepth)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .take     (take),
        .avail    (avail),
        .out_item (q_item)
    );

    sha_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .avail       (avail),
        .item        (q_item),
        .take        (take),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    `ASSERT_ALWAYS(a_take_needs_avail, clk, rst_n, !take || avail)
    `ASSERT_ALWAYS(a_last_on_seven, clk, rst_n, empty || (last_word == (word_index == 3'd7)))
    `ASSERT_NEXT(a_index_steps, clk, rst_n, !empty && pop && !last_word,
                 !empty && word_index == $past(word_index) + 3'd1)
endmodule
